FILE: design/bfsk_pkg.sv
// Shared types, constants and the sine table generator for the byte FSK tone modulator.
// Used by the top level, front end, back end and testbench; depends on nothing.
package bfsk_pkg;

    localparam int SINE_TABLE_BITS_DEFAULT = 10;
    localparam int PHASE_BITS_DEFAULT      = 32;
    localparam int QUEUE_DEPTH             = 2;
    localparam int ADDR_BITS               = 5;
    localparam int DATA_BITS               = 32;

    localparam logic [31:0] ZERO_INCREMENT_RESET   = 32'd48099738;
    localparam logic [31:0] ONE_INCREMENT_RESET    = 32'd68024101;
    localparam logic [31:0] REPEAT_INCREMENT_RESET = 32'd57200004;
    localparam logic [31:0] PAUSE_INCREMENT_RESET  = 32'd80893420;
    localparam logic [15:0] SAMPLES_PER_SYMBOL_RESET = 16'd22050;
    localparam logic [3:0]  PAUSE_SYMBOLS_RESET      = 4'd2;

    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
    localparam logic [6:0]  SINE_FULL   = 7'd127;
    localparam logic [7:0]  SINE_MID    = 8'd127;
    localparam logic [3:0]  BITS_PER_BYTE = 4'd8;

    typedef enum logic [2:0] {
        REG_ZERO_INCREMENT   = 3'd0,
        REG_ONE_INCREMENT    = 3'd1,
        REG_REPEAT_INCREMENT = 3'd2,
        REG_PAUSE_INCREMENT  = 3'd3,
        REG_SAMPLES_PER_SYMBOL = 3'd4,
        REG_PAUSE_SYMBOLS    = 3'd5
    } reg_index_t;

    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_TICK = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        TONE_ZERO   = 2'd0,
        TONE_ONE    = 2'd1,
        TONE_REPEAT = 2'd2,
        TONE_PAUSE  = 2'd3
    } tone_t;

    typedef struct packed {
        logic [31:0] zero_increment;
        logic [31:0] one_increment;
        logic [31:0] repeat_increment;
        logic [31:0] pause_increment;
        logic [15:0] samples_per_symbol;
        logic [3:0]  pause_symbols;
    } bfsk_cfg_t;

    typedef struct packed {
        tone_t tone;
        logic  byte_done;
    } bfsk_sym_t;

    // Divides a Taylor term by (2k)(2k+1) for the k-th term of the sine series.
    function automatic logic [63:0] series_div(logic [63:0] t, int unsigned k);
        case (k)
            1:       return t / 64'd6;
            2:       return t / 64'd20;
            3:       return t / 64'd42;
            4:       return t / 64'd72;
            5:       return t / 64'd110;
            6:       return t / 64'd156;
            7:       return t / 64'd210;
            8:       return t / 64'd272;
            9:       return t / 64'd342;
            10:      return t / 64'd420;
            11:      return t / 64'd506;
            12:      return t / 64'd600;
            13:      return t / 64'd702;
            default: return t / 64'd812;
        endcase
    endfunction

    // Returns floor(127 * sin(pi/2 * m / 2^qbits)) as an integer, computed in Q62 fixed point, for m below 2^qbits.
    function automatic logic [6:0] quarter_floor(int unsigned m, int unsigned qbits);
        logic [63:0]  x;
        logic [63:0]  x2;
        logic [63:0]  term;
        logic [63:0]  sum;
        logic [127:0] prod;
        x = (HALF_PI_Q62 >> qbits) * 64'(m)
          + (((HALF_PI_Q62 & ((64'd1 << qbits) - 64'd1)) * 64'(m)) >> qbits);
        prod = 128'(x) * 128'(x);
        x2 = prod[125:62];
        term = x;
        sum = x;
        for (int unsigned k = 1; k <= 14; k++)
        begin
            prod = 128'(term) * 128'(x2);
            term = series_div(prod[125:62], k);
            if (k[0])
            begin
                sum = sum - term;
            end
            else
            begin
                sum = sum + term;
            end
        end
        prod = 128'(sum) * 128'(127);
        return prod[68:62];
    endfunction

endpackage

FILE: design/byte_fsk_tone_modulator_unit.sv
// Top level of the byte FSK tone modulator: configuration registers on an APB-style
// port, front end, queue and back end. Depends on bfsk_pkg, bfsk_front, bfsk_fifo, bfsk_back.
//
// The input channel takes words with func and data_byte. A load word latches a byte
// when the block is idle and is dropped while a byte is still being sent. A tick word
// while a byte is in progress produces exactly one output word with sample, tone and
// byte_done; a tick while idle produces nothing. Bits go out least significant first,
// each for samples_per_symbol ticks, followed by pause_symbols pause symbols.
// One input word is accepted every cycle while in_stall is low. A tick's entry is
// built in the sequencer and phase accumulator, then looked up in the sine table
// into the output register. A two-entry queue sits between them, so the input side
// stalls only when that queue is full, which happens only after the receiver has
// held out_stall. A stalled output word holds its value until taken. Reset clears
// the phase accumulator and the sequencer, empties the queue, and loads every
// configuration register with its default. The sine table is constant logic and
// needs no setup. Registers are to be written only while idle; it is not enforced.
module byte_fsk_tone_modulator_unit #(
    parameter int SINE_TABLE_BITS = bfsk_pkg::SINE_TABLE_BITS_DEFAULT,
    parameter int PHASE_BITS      = bfsk_pkg::PHASE_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bfsk_pkg::ADDR_BITS-1:0] paddr,
    input  logic [bfsk_pkg::DATA_BITS-1:0] pwdata,
    output logic [bfsk_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           func,
    input  logic [7:0]                     data_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [7:0]                     sample,
    output logic [1:0]                     tone,
    output logic                           byte_done
);

    localparam int ENTRY_BITS = SINE_TABLE_BITS + $bits(bfsk_pkg::bfsk_sym_t);

    bfsk_pkg::bfsk_cfg_t         cfg_reg;
    bfsk_pkg::reg_index_t        reg_index;
    logic                        wr_en;

    logic                        push;
    logic [SINE_TABLE_BITS-1:0]  push_index;
    bfsk_pkg::bfsk_sym_t         push_sym;
    logic                        pop;
    logic                        head_valid;
    logic [ENTRY_BITS-1:0]       head_data;
    logic                        fifo_full;
    logic [SINE_TABLE_BITS-1:0]  head_index;
    bfsk_pkg::bfsk_sym_t         head_sym;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && pready;
    assign reg_index = bfsk_pkg::reg_index_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.zero_increment     <= bfsk_pkg::ZERO_INCREMENT_RESET;
            cfg_reg.one_increment      <= bfsk_pkg::ONE_INCREMENT_RESET;
            cfg_reg.repeat_increment   <= bfsk_pkg::REPEAT_INCREMENT_RESET;
            cfg_reg.pause_increment    <= bfsk_pkg::PAUSE_INCREMENT_RESET;
            cfg_reg.samples_per_symbol <= bfsk_pkg::SAMPLES_PER_SYMBOL_RESET;
            cfg_reg.pause_symbols      <= bfsk_pkg::PAUSE_SYMBOLS_RESET;
        end
        else if (wr_en)
        begin
            case (reg_index)
                bfsk_pkg::REG_ZERO_INCREMENT:     cfg_reg.zero_increment     <= pwdata;
                bfsk_pkg::REG_ONE_INCREMENT:      cfg_reg.one_increment      <= pwdata;
                bfsk_pkg::REG_REPEAT_INCREMENT:   cfg_reg.repeat_increment   <= pwdata;
                bfsk_pkg::REG_PAUSE_INCREMENT:    cfg_reg.pause_increment    <= pwdata;
                bfsk_pkg::REG_SAMPLES_PER_SYMBOL: cfg_reg.samples_per_symbol <= pwdata[15:0];
                bfsk_pkg::REG_PAUSE_SYMBOLS:      cfg_reg.pause_symbols      <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            bfsk_pkg::REG_ZERO_INCREMENT:     prdata = cfg_reg.zero_increment;
            bfsk_pkg::REG_ONE_INCREMENT:      prdata = cfg_reg.one_increment;
            bfsk_pkg::REG_REPEAT_INCREMENT:   prdata = cfg_reg.repeat_increment;
            bfsk_pkg::REG_PAUSE_INCREMENT:    prdata = cfg_reg.pause_increment;
            bfsk_pkg::REG_SAMPLES_PER_SYMBOL: prdata = {16'd0, cfg_reg.samples_per_symbol};
            bfsk_pkg::REG_PAUSE_SYMBOLS:      prdata = {28'd0, cfg_reg.pause_symbols};
            default:                          prdata = '0;
        endcase
    end

    assign in_stall = fifo_full;

    bfsk_front #(
        .SINE_TABLE_BITS(SINE_TABLE_BITS),
        .PHASE_BITS     (PHASE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .data_byte (data_byte),
        .push      (push),
        .push_index(push_index),
        .push_sym  (push_sym)
    );

    bfsk_fifo #(
        .WIDTH(ENTRY_BITS),
        .DEPTH(bfsk_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_index, push_sym}),
        .pop       (pop),
        .head_valid(head_valid),
        .head_data (head_data),
        .full      (fifo_full)
    );

    assign head_index = head_data[ENTRY_BITS-1 -: SINE_TABLE_BITS];
    assign head_sym   = bfsk_pkg::bfsk_sym_t'(head_data[$bits(bfsk_pkg::bfsk_sym_t)-1:0]);

    bfsk_back #(
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_valid(head_valid),
        .head_index(head_index),
        .head_sym  (head_sym),
        .pop       (pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .sample    (sample),
        .tone      (tone),
        .byte_done (byte_done)
    );

endmodule

FILE: design/bfsk_front.sv
// Front end of the byte FSK tone modulator: accepts load and tick words, runs the
// symbol sequencer and the phase accumulator, and queues one entry per sample.
// Depends on bfsk_pkg.
module bfsk_front #(
    parameter int SINE_TABLE_BITS = bfsk_pkg::SINE_TABLE_BITS_DEFAULT,
    parameter int PHASE_BITS      = bfsk_pkg::PHASE_BITS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bfsk_pkg::bfsk_cfg_t         cfg,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic                        func,
    input  logic [7:0]                  data_byte,
    output logic                        push,
    output logic [SINE_TABLE_BITS-1:0]  push_index,
    output bfsk_pkg::bfsk_sym_t         push_sym
);

    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic                  prev_bit_reg, prev_bit_next;
    logic                  blocked_reg, blocked_next;
    logic [7:0]            shift_reg, shift_next;
    logic [3:0]            bits_reg, bits_next;
    bfsk_pkg::tone_t       tone_reg, tone_next;
    logic [15:0]           sidx_reg, sidx_next;
    logic [3:0]            pidx_reg, pidx_next;
    logic                  busy_reg, busy_next;

    logic                  accept;
    logic                  is_load;
    logic [7:0]            nb_src;
    logic                  nb_bit;
    logic                  nb_repeat;
    bfsk_pkg::tone_t       nb_tone;
    logic [31:0]           incr;
    logic [15:0]           sps_eff;
    logic [15:0]           sidx_inc;
    logic [3:0]            pidx_inc;
    logic                  sym_end;
    logic                  done;

    assign accept  = in_valid && !in_stall;
    assign is_load = (func == bfsk_pkg::FUNC_LOAD);
    assign nb_src  = is_load ? data_byte : shift_reg;
    assign nb_bit  = nb_src[0];
    assign nb_repeat = (nb_bit == prev_bit_reg) && !blocked_reg;
    assign nb_tone = nb_repeat ? bfsk_pkg::TONE_REPEAT
                   : (nb_bit ? bfsk_pkg::TONE_ONE : bfsk_pkg::TONE_ZERO);
    assign sps_eff  = (cfg.samples_per_symbol == 16'd0) ? 16'd1 : cfg.samples_per_symbol;
    assign sidx_inc = sidx_reg + 16'd1;
    assign pidx_inc = pidx_reg + 4'd1;
    assign sym_end  = (sidx_inc == 16'd0) || (sidx_inc >= sps_eff);

    always_comb
    begin
        case (tone_reg)
            bfsk_pkg::TONE_ZERO:   incr = cfg.zero_increment;
            bfsk_pkg::TONE_ONE:    incr = cfg.one_increment;
            bfsk_pkg::TONE_REPEAT: incr = cfg.repeat_increment;
            default:               incr = cfg.pause_increment;
        endcase
    end

    always_comb
    begin
        phase_next    = phase_reg;
        prev_bit_next = prev_bit_reg;
        blocked_next  = blocked_reg;
        shift_next    = shift_reg;
        bits_next     = bits_reg;
        tone_next     = tone_reg;
        sidx_next     = sidx_reg;
        pidx_next     = pidx_reg;
        busy_next     = busy_reg;
        push          = 1'b0;
        done          = 1'b0;
        if (accept && is_load && !busy_reg)
        begin
            shift_next    = {1'b0, data_byte[7:1]};
            bits_next     = bfsk_pkg::BITS_PER_BYTE;
            sidx_next     = 16'd0;
            pidx_next     = 4'd0;
            busy_next     = 1'b1;
            tone_next     = nb_tone;
            blocked_next  = nb_repeat;
            prev_bit_next = nb_bit;
        end
        else if (accept && !is_load && busy_reg)
        begin
            push       = 1'b1;
            phase_next = phase_reg + PHASE_BITS'(incr);
            if (sym_end)
            begin
                sidx_next = 16'd0;
                if (bits_reg != 4'd0)
                begin
                    bits_next = bits_reg - 4'd1;
                    if (bits_reg != 4'd1)
                    begin
                        shift_next    = {1'b0, shift_reg[7:1]};
                        tone_next     = nb_tone;
                        blocked_next  = nb_repeat;
                        prev_bit_next = nb_bit;
                    end
                    else
                    begin
                        blocked_next = 1'b1;
                        tone_next    = bfsk_pkg::TONE_PAUSE;
                        pidx_next    = 4'd0;
                        if (cfg.pause_symbols == 4'd0)
                        begin
                            busy_next = 1'b0;
                            done      = 1'b1;
                        end
                    end
                end
                else if ((pidx_inc == 4'd0) || (pidx_inc >= cfg.pause_symbols))
                begin
                    pidx_next = 4'd0;
                    busy_next = 1'b0;
                    done      = 1'b1;
                end
                else
                begin
                    pidx_next = pidx_inc;
                end
            end
            else
            begin
                sidx_next = sidx_inc;
            end
        end
    end

    assign push_index         = phase_reg[PHASE_BITS-1 -: SINE_TABLE_BITS];
    assign push_sym.tone      = tone_reg;
    assign push_sym.byte_done = done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= '0;
            prev_bit_reg <= 1'b0;
            blocked_reg  <= 1'b1;
            shift_reg    <= 8'd0;
            bits_reg     <= 4'd0;
            tone_reg     <= bfsk_pkg::TONE_ZERO;
            sidx_reg     <= 16'd0;
            pidx_reg     <= 4'd0;
            busy_reg     <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            prev_bit_reg <= prev_bit_next;
            blocked_reg  <= blocked_next;
            shift_reg    <= shift_next;
            bits_reg     <= bits_next;
            tone_reg     <= tone_next;
            sidx_reg     <= sidx_next;
            pidx_reg     <= pidx_next;
            busy_reg     <= busy_next;
        end
    end

endmodule

FILE: design/bfsk_fifo.sv
// Short first-in first-out queue that carries sample entries from front to back end.
// Depends on bfsk_pkg only through the parameters handed to it.
module bfsk_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data,
    output logic             full
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == CNT_BITS'(DEPTH));
    assign head_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                        : wr_ptr_reg + PTR_BITS'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                        : rd_ptr_reg + PTR_BITS'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: design/bfsk_back.sv
// Back end of the byte FSK tone modulator: takes queued entries, looks up the sine
// table by quarter-wave symmetry and holds the result word in the output register.
// Depends on bfsk_pkg.
module bfsk_back #(
    parameter int SINE_TABLE_BITS = bfsk_pkg::SINE_TABLE_BITS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        head_valid,
    input  logic [SINE_TABLE_BITS-1:0]  head_index,
    input  bfsk_pkg::bfsk_sym_t         head_sym,
    output logic                        pop,
    input  logic                        out_stall,
    output logic                        out_valid,
    output logic [7:0]                  sample,
    output logic [1:0]                  tone,
    output logic                        byte_done
);

    localparam int QB      = SINE_TABLE_BITS - 2;
    localparam int QUARTER = 1 << QB;

    logic [6:0]    qtab [QUARTER];
    logic [QB-1:0] j;
    logic [QB:0]   m;
    logic          exact;
    logic [6:0]    f;
    logic [7:0]    sample_value;

    logic          valid_reg, valid_next;
    logic [7:0]    sample_reg;
    logic [1:0]    tone_reg;
    logic          done_reg;

    for (genvar g = 0; g < QUARTER; g++)
    begin : g_qtab
        assign qtab[g] = bfsk_pkg::quarter_floor(g, QB);
    end

    assign j     = head_index[QB-1:0];
    assign m     = head_index[QB] ? ((QB+1)'(QUARTER) - {1'b0, j}) : {1'b0, j};
    assign exact = (m == '0) || m[QB];
    assign f     = m[QB] ? bfsk_pkg::SINE_FULL : qtab[m[QB-1:0]];

    always_comb
    begin
        if (!head_index[SINE_TABLE_BITS-1])
        begin
            sample_value = bfsk_pkg::SINE_MID + {1'b0, f};
        end
        else
        begin
            sample_value = bfsk_pkg::SINE_MID - {1'b0, f} - (exact ? 8'd0 : 8'd1);
        end
    end

    assign pop        = head_valid && (!valid_reg || !out_stall);
    assign valid_next = pop || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            sample_reg <= sample_value;
            tone_reg   <= head_sym.tone;
            done_reg   <= head_sym.byte_done;
        end
    end

    assign out_valid = valid_reg;
    assign sample    = sample_reg;
    assign tone      = tone_reg;
    assign byte_done = done_reg;

endmodule

FILE: design/bfsk_checker.sv
// Port-level checks for the byte FSK tone modulator, bound to the top level.
// Depends on byte_fsk_tone_modulator_unit for the bind target.
module bfsk_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] sample,
    input logic [1:0] tone,
    input logic       byte_done
);

    // A stalled output word stays valid.
    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output word dropped while stalled");

    // A stalled output word keeps its payload.
    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(sample) && $stable(tone) && $stable(byte_done))
        else $error("output payload changed while stalled");

    // The sine table never reaches the top code.
    a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sample != 8'hFF)
        else $error("sample out of table range");

    // With the output register empty the queue has room, so input is never stalled.
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output register is empty");

endmodule

bind byte_fsk_tone_modulator_unit bfsk_checker u_bfsk_checker (.*);

FILE: bench/byte_fsk_tone_modulator_unit_tb.sv
// Self-checking testbench for byte_fsk_tone_modulator_unit: a directed table, then random
// load and tick words under varied idling, checked against a tone and sine-table predictor.
// Depends on bfsk_pkg and the design; reads no files.
module byte_fsk_tone_modulator_unit_tb;

    localparam int          TABLE_BITS   = 10;
    localparam int          TABLE_SIZE   = 1 << TABLE_BITS;
    localparam int          QUARTER_BITS = TABLE_BITS - 2;
    localparam int          QUARTER      = 1 << QUARTER_BITS;
    localparam logic [63:0] HALF_PI      = 64'h6487ED5110B4611A;
    localparam logic [63:0] ONE_Q62      = 64'h4000000000000000;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int          ROW_COUNT    = 25;
    localparam int          PHASE_COUNT  = 6;

    typedef struct packed {
        logic [7:0]       sample;
        bfsk_pkg::tone_t  tone;
        logic             byte_done;
    } tick_out_t;

    typedef struct packed {
        bfsk_pkg::func_t  f;
        logic [7:0]       b;
        bit               typed;
        tick_out_t        want;
    } stim_row_t;

    typedef struct packed {
        logic [31:0] zero_inc;
        logic [31:0] one_inc;
        logic [31:0] rep_inc;
        logic [31:0] pause_inc;
        logic [15:0] sps;
        logic [3:0]  ps;
        bit          rand_inc;
        int unsigned send_idle;
        int unsigned recv_stall;
        int unsigned words;
        int unsigned hold;
    } run_phase_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [bfsk_pkg::ADDR_BITS-1:0] paddr;
    logic [bfsk_pkg::DATA_BITS-1:0] pwdata;
    logic [bfsk_pkg::DATA_BITS-1:0] prdata;
    logic                           pready;
    logic                           in_valid;
    logic                           in_stall;
    logic                           func;
    logic [7:0]                     data_byte;
    logic                           out_valid;
    logic                           out_stall;
    logic [7:0]                     sample;
    logic [1:0]                     tone;
    logic                           byte_done;

    logic      word_typed;
    tick_out_t word_want;

    int unsigned send_idle    = 0;
    int unsigned stall_pct    = 0;
    int unsigned hold_request = 0;
    int unsigned hold_left    = 0;
    int unsigned cycle_count  = 0;
    int unsigned fail_count   = 0;

    logic [7:0] sine_tbl [0:TABLE_SIZE-1];
    tick_out_t  expected_samples [$];

    bfsk_pkg::bfsk_cfg_t cfg = '{bfsk_pkg::ZERO_INCREMENT_RESET,
                                 bfsk_pkg::ONE_INCREMENT_RESET,
                                 bfsk_pkg::REPEAT_INCREMENT_RESET,
                                 bfsk_pkg::PAUSE_INCREMENT_RESET,
                                 bfsk_pkg::SAMPLES_PER_SYMBOL_RESET,
                                 bfsk_pkg::PAUSE_SYMBOLS_RESET};
    logic [31:0]     nco_phase   = '0;
    logic            last_bit    = 1'b0;
    logic            repeat_lock = 1'b1;
    logic [7:0]      bits_shift  = '0;
    logic [3:0]      bits_left   = '0;
    bfsk_pkg::tone_t cur_tone    = bfsk_pkg::TONE_ZERO;
    logic [15:0]     sym_count   = '0;
    logic [3:0]      pause_count = '0;
    logic            sending     = 1'b0;

    byte_fsk_tone_modulator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .data_byte (data_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sample    (sample),
        .tone      (tone),
        .byte_done (byte_done)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return 64'(p >> 62);
    endfunction

    initial
    begin : sine_setup
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] f;
        int unsigned q;
        int unsigned j;
        int unsigned m;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            q = i >> QUARTER_BITS;
            j = i % QUARTER;
            m = (q % 2 == 1) ? QUARTER - j : j;
            if (m >= QUARTER)
            begin
                acc = ONE_Q62;
            end
            else
            begin
                x = (HALF_PI >> QUARTER_BITS) * 64'(m)
                  + (((HALF_PI & 64'(QUARTER - 1)) * 64'(m)) >> QUARTER_BITS);
                x2 = q62_mul(x, x);
                term = x;
                acc = x;
                for (int k = 1; k <= 14; k++)
                begin
                    term = q62_mul(term, x2) / 64'((2 * k) * (2 * k + 1));
                    if (k % 2 == 1)
                    begin
                        acc = acc - term;
                    end
                    else
                    begin
                        acc = acc + term;
                    end
                end
            end
            f = q62_mul(acc, 64'd127);
            if (q < 2)
            begin
                sine_tbl[i] = 8'(64'd127 + f);
            end
            else if (m == 0 || m == QUARTER)
            begin
                sine_tbl[i] = 8'(64'd127 - f);
            end
            else
            begin
                sine_tbl[i] = 8'(64'd126 - f);
            end
        end
    end

    task automatic pick_bit_tone();
        logic lsb;
        lsb = bits_shift[0];
        bits_shift = bits_shift >> 1;
        if (lsb == last_bit && !repeat_lock)
        begin
            cur_tone = bfsk_pkg::TONE_REPEAT;
            repeat_lock = 1'b1;
        end
        else
        begin
            cur_tone = lsb ? bfsk_pkg::TONE_ONE : bfsk_pkg::TONE_ZERO;
            repeat_lock = 1'b0;
        end
        last_bit = lsb;
    endtask

    task automatic modulate_word(input logic f, input logic [7:0] b,
                                 output bit made, output tick_out_t o);
        logic [31:0] incr;
        int unsigned len;
        made = 1'b0;
        o = '0;
        if (f == bfsk_pkg::FUNC_LOAD)
        begin
            if (!sending)
            begin
                bits_shift = b;
                bits_left = bfsk_pkg::BITS_PER_BYTE;
                sym_count = '0;
                pause_count = '0;
                sending = 1'b1;
                pick_bit_tone();
            end
        end
        else if (sending)
        begin
            made = 1'b1;
            o.sample = sine_tbl[nco_phase[31 -: TABLE_BITS]];
            o.tone = cur_tone;
            case (cur_tone)
                bfsk_pkg::TONE_ZERO:   incr = cfg.zero_increment;
                bfsk_pkg::TONE_ONE:    incr = cfg.one_increment;
                bfsk_pkg::TONE_REPEAT: incr = cfg.repeat_increment;
                default:               incr = cfg.pause_increment;
            endcase
            nco_phase = nco_phase + incr;
            len = (cfg.samples_per_symbol == 0) ? 1 : cfg.samples_per_symbol;
            sym_count = sym_count + 16'd1;
            if (sym_count == 0 || sym_count >= len)
            begin
                sym_count = '0;
                if (bits_left != 0)
                begin
                    bits_left = bits_left - 4'd1;
                    if (bits_left != 0)
                    begin
                        pick_bit_tone();
                    end
                    else
                    begin
                        repeat_lock = 1'b1;
                        cur_tone = bfsk_pkg::TONE_PAUSE;
                        pause_count = '0;
                        if (cfg.pause_symbols == 0)
                        begin
                            sending = 1'b0;
                            o.byte_done = 1'b1;
                        end
                    end
                end
                else
                begin
                    pause_count = pause_count + 4'd1;
                    if (pause_count == 0 || pause_count >= cfg.pause_symbols)
                    begin
                        pause_count = '0;
                        sending = 1'b0;
                        o.byte_done = 1'b1;
                    end
                end
            end
        end
    endtask

    always @(posedge clk)
    begin : watch
        tick_out_t want;
        bit        made;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                modulate_word(func, data_byte, made, want);
                if (made)
                begin
                    if (word_typed)
                    begin
                        want = word_want;
                    end
                    expected_samples.push_back(want);
                end
            end
            if (out_valid && !out_stall)
            begin
                if (expected_samples.size() == 0)
                begin
                    $error("Output word with no expected word: sample %0d tone %0d done %0d",
                           sample, tone, byte_done);
                    fail_count++;
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (sample !== want.sample)
                    begin
                        $error("sample: expected %0d, got %0d", want.sample, sample);
                        fail_count++;
                    end
                    if (tone !== want.tone)
                    begin
                        $error("tone: expected %0d, got %0d", want.tone, tone);
                        fail_count++;
                    end
                    if (byte_done !== want.byte_done)
                    begin
                        $error("byte_done: expected %0d, got %0d", want.byte_done, byte_done);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic reg_check(input bfsk_pkg::reg_index_t r);
        logic [31:0] want;
        logic [31:0] got;
        case (r)
            bfsk_pkg::REG_ZERO_INCREMENT:     want = cfg.zero_increment;
            bfsk_pkg::REG_ONE_INCREMENT:      want = cfg.one_increment;
            bfsk_pkg::REG_REPEAT_INCREMENT:   want = cfg.repeat_increment;
            bfsk_pkg::REG_PAUSE_INCREMENT:    want = cfg.pause_increment;
            bfsk_pkg::REG_SAMPLES_PER_SYMBOL: want = 32'(cfg.samples_per_symbol);
            default:                          want = 32'(cfg.pause_symbols);
        endcase
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {r, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        got = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (got !== want)
        begin
            $error("register %s: expected %0d, got %0d", r.name(), want, got);
            fail_count++;
        end
    endtask

    task automatic reg_write(input bfsk_pkg::reg_index_t r, input logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        case (r)
            bfsk_pkg::REG_ZERO_INCREMENT:     cfg.zero_increment = v;
            bfsk_pkg::REG_ONE_INCREMENT:      cfg.one_increment = v;
            bfsk_pkg::REG_REPEAT_INCREMENT:   cfg.repeat_increment = v;
            bfsk_pkg::REG_PAUSE_INCREMENT:    cfg.pause_increment = v;
            bfsk_pkg::REG_SAMPLES_PER_SYMBOL: cfg.samples_per_symbol = v[15:0];
            default:                          cfg.pause_symbols = v[3:0];
        endcase
        reg_check(r);
    endtask

    task automatic put_word(input bfsk_pkg::func_t f, input logic [7:0] b,
                            input bit typed, input tick_out_t t);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        data_byte <= b;
        word_typed <= typed;
        word_want <= t;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sending)
        begin
            put_word(bfsk_pkg::FUNC_TICK, 8'($urandom), 1'b0, '0);
            in_valid <= 1'b0;
            @(posedge clk);
        end
        while (expected_samples.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned sent;
        int unsigned ticks;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(99) < 85)
            begin
                put_word(bfsk_pkg::FUNC_LOAD, 8'($urandom), 1'b0, '0);
                ticks = (8 + cfg.pause_symbols)
                      * ((cfg.samples_per_symbol == 0) ? 1 : cfg.samples_per_symbol)
                      + $urandom_range(2);
                for (int unsigned i = 0; i < ticks; i++)
                begin
                    if ($urandom_range(99) < 5)
                    begin
                        put_word(bfsk_pkg::FUNC_LOAD, 8'($urandom), 1'b0, '0);
                    end
                    put_word(bfsk_pkg::FUNC_TICK, 8'($urandom), 1'b0, '0);
                end
                sent += 1 + ticks;
            end
            else
            begin
                put_word(bfsk_pkg::func_t'($urandom_range(1)), 8'($urandom), 1'b0, '0);
                sent++;
            end
        end
    endtask

    initial
    begin : main
        stim_row_t  rows [ROW_COUNT];
        run_phase_t plan [PHASE_COUNT];
        run_phase_t ph;

        rows[0]  = '{bfsk_pkg::FUNC_TICK, 8'h00, 1'b0, '0};
        rows[1]  = '{bfsk_pkg::FUNC_LOAD, 8'h00, 1'b0, '0};
        rows[2]  = '{bfsk_pkg::FUNC_TICK, 8'hFF, 1'b1, '{8'd127, bfsk_pkg::TONE_ZERO, 1'b0}};
        rows[3]  = '{bfsk_pkg::FUNC_LOAD, 8'hFF, 1'b0, '0};
        rows[4]  = '{bfsk_pkg::FUNC_TICK, 8'h00, 1'b1, '{8'd127, bfsk_pkg::TONE_REPEAT, 1'b0}};
        rows[5]  = '{bfsk_pkg::FUNC_TICK, 8'h00, 1'b1, '{8'd127, bfsk_pkg::TONE_ZERO, 1'b0}};
        rows[6]  = '{bfsk_pkg::FUNC_TICK, 8'h00, 1'b1, '{8'd127, bfsk_pkg::TONE_REPEAT, 1'b0}};
        rows[7]  = '{bfsk_pkg::FUNC_TICK, 8'h00, 1'b1, '{8'd127, bfsk_pkg::TONE_ZERO, 1'b0}};
        rows[8]  = '{bfsk_pkg::FUNC_TICK, 8'h00, 1'b1, '{8'd127, bfsk_pkg::TONE_REPEAT, 1'b0}};
        rows[9]  = '{bfsk_pkg::FUNC_TICK, 8'h00, 1'b1, '{8'd127, bfsk_pkg::TONE_ZERO, 1'b0}};
        rows[10] = '{bfsk_pkg::FUNC_TICK, 8'h00, 1'b1, '{8'd127, bfsk_pkg::TONE_REPEAT, 1'b0}};
        rows[11] = '{bfsk_pkg::FUNC_TICK, 8'h00, 1'b1, '{8'd127, bfsk_pkg::TONE_PAUSE, 1'b1}};
        rows[12] = '{bfsk_pkg::FUNC_LOAD, 8'hFF, 1'b0, '0};
        rows[13] = '{bfsk_pkg::FUNC_TICK, 8'hFF, 1'b1, '{8'd127, bfsk_pkg::TONE_ONE, 1'b0}};
        rows[14] = '{bfsk_pkg::FUNC_TICK, 8'hFF, 1'b1, '{8'd254, bfsk_pkg::TONE_REPEAT, 1'b0}};
        rows[15] = '{bfsk_pkg::FUNC_TICK, 8'hFF, 1'b1, '{8'd254, bfsk_pkg::TONE_ONE, 1'b0}};
        rows[16] = '{bfsk_pkg::FUNC_TICK, 8'hFF, 1'b1, '{8'd127, bfsk_pkg::TONE_REPEAT, 1'b0}};
        rows[17] = '{bfsk_pkg::FUNC_TICK, 8'hFF, 1'b1, '{8'd127, bfsk_pkg::TONE_ONE, 1'b0}};
        rows[18] = '{bfsk_pkg::FUNC_TICK, 8'hFF, 1'b1, '{8'd0, bfsk_pkg::TONE_REPEAT, 1'b0}};
        rows[19] = '{bfsk_pkg::FUNC_TICK, 8'hFF, 1'b1, '{8'd0, bfsk_pkg::TONE_ONE, 1'b0}};
        rows[20] = '{bfsk_pkg::FUNC_TICK, 8'hFF, 1'b1, '{8'd127, bfsk_pkg::TONE_REPEAT, 1'b0}};
        rows[21] = '{bfsk_pkg::FUNC_TICK, 8'hFF, 1'b1, '{8'd127, bfsk_pkg::TONE_PAUSE, 1'b1}};
        rows[22] = '{bfsk_pkg::FUNC_LOAD, 8'h5A, 1'b0, '0};
        rows[23] = '{bfsk_pkg::FUNC_TICK, 8'hA5, 1'b0, '0};
        rows[24] = '{bfsk_pkg::FUNC_TICK, 8'h5A, 1'b0, '0};

        plan[0] = '{32'h0, 32'hFFFFFFFF, 32'h1, 32'h80000000, 16'd1, 4'd0,
                    1'b0, 0, 0, 300, 0};
        plan[1] = '{32'h0, 32'h0, 32'h0, 32'h0, 16'd3, 4'd15, 1'b1, 73, 0, 350, 0};
        plan[2] = '{32'h0, 32'h0, 32'h0, 32'h0, 16'd2, 4'd1, 1'b1, 0, 73, 350, 300};
        plan[3] = '{32'h0, 32'h0, 32'h0, 32'h0, 16'd1, 4'd7, 1'b1, 27, 27, 350, 0};
        plan[4] = '{32'h0, 32'h0, 32'h0, 32'h0, 16'd0, 4'd2, 1'b1, 0, 0, 300, 0};
        plan[5] = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'd65535, 4'd15,
                    1'b0, 27, 27, 300, 0};

        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        func = bfsk_pkg::FUNC_LOAD;
        data_byte = '0;
        out_stall = 1'b0;
        word_typed = 1'b0;
        word_want = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = bfsk_pkg::REG_ZERO_INCREMENT; r <= bfsk_pkg::REG_PAUSE_SYMBOLS; r++)
        begin
            reg_check(bfsk_pkg::reg_index_t'(r));
        end

        // A quarter turn per one-tone sample walks the table through its peaks.
        reg_write(bfsk_pkg::REG_ZERO_INCREMENT, 32'h0);
        reg_write(bfsk_pkg::REG_ONE_INCREMENT, 32'h40000000);
        reg_write(bfsk_pkg::REG_REPEAT_INCREMENT, 32'h0);
        reg_write(bfsk_pkg::REG_PAUSE_INCREMENT, 32'h0);
        reg_write(bfsk_pkg::REG_SAMPLES_PER_SYMBOL, 32'd1);
        reg_write(bfsk_pkg::REG_PAUSE_SYMBOLS, 32'd1);

        for (int i = 0; i < ROW_COUNT; i++)
        begin
            put_word(rows[i].f, rows[i].b, rows[i].typed, rows[i].want);
        end

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            ph = plan[p];
            send_idle = 0;
            stall_pct = 0;
            settle();
            if (ph.rand_inc)
            begin
                ph.zero_inc = $urandom;
                ph.one_inc = $urandom;
                ph.rep_inc = $urandom;
                ph.pause_inc = $urandom;
            end
            reg_write(bfsk_pkg::REG_ZERO_INCREMENT, ph.zero_inc);
            reg_write(bfsk_pkg::REG_ONE_INCREMENT, ph.one_inc);
            reg_write(bfsk_pkg::REG_REPEAT_INCREMENT, ph.rep_inc);
            reg_write(bfsk_pkg::REG_PAUSE_INCREMENT, ph.pause_inc);
            reg_write(bfsk_pkg::REG_SAMPLES_PER_SYMBOL, 32'(ph.sps));
            reg_write(bfsk_pkg::REG_PAUSE_SYMBOLS, 32'(ph.ps));
            send_idle = ph.send_idle;
            stall_pct = ph.recv_stall;
            hold_request = ph.hold;
            if (ph.sps > 16)
            begin
                // Longest symbols: only the opening stretch of one byte is sent.
                put_word(bfsk_pkg::FUNC_LOAD, 8'($urandom), 1'b0, '0);
                for (int unsigned i = 0; i < ph.words; i++)
                begin
                    put_word(bfsk_pkg::FUNC_TICK, 8'($urandom), 1'b0, '0);
                end
            end
            else
            begin
                run_random(ph.words);
            end
        end

        in_valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
